>>> rtl/core/tkls_pkg.sv
// Shared constants, types and sequencer states of the top-K selector.
package tkls_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SIZE_W   = 48;
    localparam int TAG_W    = 48;
    localparam int KEEP_W   = 4;
    localparam int LIM_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int ENTRY_W  = SIZE_W + TAG_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
        logic   last;
    } push_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_UP,
        ST_DOWN,
        ST_PLACE,
        ST_DRAIN
    } state_t;

endpackage

>>> rtl/core/tkls_if.sv
// Channel interfaces of the top-K selector: command, result and configuration.
interface tkls_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [tkls_pkg::SIZE_W-1:0] entry_size;
    logic [tkls_pkg::TAG_W-1:0]  entry_tag;

    modport source (output valid, opcode, entry_size, entry_tag, input ready);
    modport sink   (input valid, opcode, entry_size, entry_tag, output ready);
endinterface

interface tkls_res_if;
    logic                        valid;
    logic                        ready;
    logic [tkls_pkg::SIZE_W-1:0] out_size;
    logic [tkls_pkg::TAG_W-1:0]  out_tag;
    logic                        last;

    modport source (output valid, out_size, out_tag, last, input ready);
    modport sink   (input valid, out_size, out_tag, last, output ready);
endinterface

interface tkls_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tkls_pkg::KEEP_W-1:0] keep_count;

    modport source (output valid, keep_count, input ready);
    modport sink   (input valid, keep_count, output ready);
endinterface

>>> rtl/core/tkls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/tkls_engine.sv
// Sequencer and shared key comparator that keep the held entries sorted.
module tkls_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    tkls_cmd_if.sink                        cmd,
    input  logic [tkls_pkg::KEEP_W-1:0]     keep_count,
    input  tkls_pkg::entry_t                rd_entry,
    input  logic                            out_space,
    output logic [tkls_pkg::IDX_W-1:0]      raddr,
    output tkls_pkg::ram_wr_t               wr,
    output tkls_pkg::push_t                 push
);

    tkls_pkg::state_t                 state_reg, state_next;
    logic [tkls_pkg::IDX_W-1:0]       raddr_reg, raddr_next;
    logic [tkls_pkg::IDX_W-1:0]       wptr_reg, wptr_next;
    logic [tkls_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             grow_reg, grow_next;
    tkls_pkg::entry_t                 item_reg;

    logic [tkls_pkg::LIM_W-1:0]       keep_w, cap_w, limit;
    logic                             below_limit;
    logic [tkls_pkg::SIZE_W-1:0]      cmp_a, cmp_b;
    logic                             a_gt_b;
    logic                             at_end;
    logic                             accept;
    tkls_pkg::entry_t                 cmd_entry;

    // Clamp the retain limit to the store capacity.
    assign keep_w      = tkls_pkg::LIM_W'(keep_count);
    assign cap_w       = tkls_pkg::LIM_W'(tkls_pkg::CAPACITY);
    assign limit       = (keep_w > cap_w) ? cap_w : keep_w;
    assign below_limit = tkls_pkg::LIM_W'(count_reg) < limit;

    // One comparator: head check asks new > smallest, scans ask held > new.
    assign cmp_a  = (state_reg == tkls_pkg::ST_HEAD) ? item_reg.size : rd_entry.size;
    assign cmp_b  = (state_reg == tkls_pkg::ST_HEAD) ? rd_entry.size : item_reg.size;
    assign a_gt_b = cmp_a > cmp_b;

    assign at_end    = (tkls_pkg::CNT_W'(raddr_reg) + tkls_pkg::CNT_W'(1)) == count_reg;
    assign cmd.ready = (state_reg == tkls_pkg::ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_entry = '{size: cmd.entry_size, tag: cmd.entry_tag};
    assign raddr     = raddr_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == tkls_pkg::OP_DRAIN)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = tkls_pkg::ST_DRAIN;
                        end
                    end
                    else if (limit != '0)
                    begin
                        if (!below_limit)
                        begin
                            state_next = tkls_pkg::ST_HEAD;
                        end
                        else if (count_reg != '0)
                        begin
                            state_next = tkls_pkg::ST_DOWN;
                        end
                    end
                end
            end
            tkls_pkg::ST_HEAD:
            begin
                if (!a_gt_b || count_reg == tkls_pkg::CNT_W'(1))
                begin
                    state_next = tkls_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tkls_pkg::ST_UP;
                end
            end
            tkls_pkg::ST_UP:
            begin
                if (a_gt_b)
                begin
                    state_next = tkls_pkg::ST_IDLE;
                end
                else if (at_end)
                begin
                    state_next = tkls_pkg::ST_PLACE;
                end
            end
            tkls_pkg::ST_DOWN:
            begin
                if (!a_gt_b)
                begin
                    state_next = tkls_pkg::ST_IDLE;
                end
                else if (raddr_reg == '0)
                begin
                    state_next = tkls_pkg::ST_PLACE;
                end
            end
            tkls_pkg::ST_PLACE:
            begin
                state_next = tkls_pkg::ST_IDLE;
            end
            tkls_pkg::ST_DRAIN:
            begin
                if (out_space && at_end)
                begin
                    state_next = tkls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkls_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        raddr_next = raddr_reg;
        wptr_next  = wptr_reg;
        count_next = count_reg;
        grow_next  = grow_reg;
        wr         = '{en: 1'b0, addr: raddr_reg, data: rd_entry};
        push       = '{valid: 1'b0, entry: rd_entry, last: at_end};
        unique case (state_reg)
            tkls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == tkls_pkg::OP_DRAIN)
                    begin
                        raddr_next = '0;
                    end
                    else if (limit != '0)
                    begin
                        if (!below_limit)
                        begin
                            raddr_next = '0;
                            grow_next  = 1'b0;
                        end
                        else if (count_reg == '0)
                        begin
                            // Empty store: place the entry at once.
                            wr         = '{en: 1'b1, addr: '0, data: cmd_entry};
                            count_next = tkls_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            raddr_next = tkls_pkg::IDX_W'(count_reg - tkls_pkg::CNT_W'(1));
                            grow_next  = 1'b1;
                        end
                    end
                end
            end
            tkls_pkg::ST_HEAD:
            begin
                if (a_gt_b)
                begin
                    if (count_reg == tkls_pkg::CNT_W'(1))
                    begin
                        wr = '{en: 1'b1, addr: '0, data: item_reg};
                    end
                    else
                    begin
                        raddr_next = tkls_pkg::IDX_W'(1);
                    end
                end
            end
            tkls_pkg::ST_UP:
            begin
                // Shift smaller-or-equal entries down over the evicted head.
                if (a_gt_b)
                begin
                    wr = '{en: 1'b1, addr: raddr_reg - tkls_pkg::IDX_W'(1), data: item_reg};
                end
                else
                begin
                    wr = '{en: 1'b1, addr: raddr_reg - tkls_pkg::IDX_W'(1), data: rd_entry};
                    if (at_end)
                    begin
                        wptr_next = raddr_reg;
                    end
                    else
                    begin
                        raddr_next = raddr_reg + tkls_pkg::IDX_W'(1);
                    end
                end
            end
            tkls_pkg::ST_DOWN:
            begin
                // Shift larger entries up to open the slot.
                if (a_gt_b)
                begin
                    wr = '{en: 1'b1, addr: raddr_reg + tkls_pkg::IDX_W'(1), data: rd_entry};
                    if (raddr_reg == '0)
                    begin
                        wptr_next = '0;
                    end
                    else
                    begin
                        raddr_next = raddr_reg - tkls_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    wr = '{en: 1'b1, addr: raddr_reg + tkls_pkg::IDX_W'(1), data: item_reg};
                    count_next = count_reg + tkls_pkg::CNT_W'(1);
                end
            end
            tkls_pkg::ST_PLACE:
            begin
                wr = '{en: 1'b1, addr: wptr_reg, data: item_reg};
                if (grow_reg)
                begin
                    count_next = count_reg + tkls_pkg::CNT_W'(1);
                end
            end
            tkls_pkg::ST_DRAIN:
            begin
                if (out_space)
                begin
                    push.valid = 1'b1;
                    if (at_end)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        raddr_next = raddr_reg + tkls_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                raddr_next = raddr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkls_pkg::ST_IDLE;
            count_reg <= '0;
            raddr_reg <= '0;
            wptr_reg  <= '0;
            grow_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            raddr_reg <= raddr_next;
            wptr_reg  <= wptr_next;
            grow_reg  <= grow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_entry;
        end
    end

endmodule

>>> rtl/core/top_k_largest_selector.sv
// Top level of the top-K selector: configuration, store, sequencer and result register.
//
// Usage:
//   cfg    - write channel for keep_count, the number of largest entries kept
//            (clamped to the store capacity of 8; 0 ignores every add).
//            Write it only while the block is idle.
//   cmd    - one item per handshake: opcode add (entry_size, entry_tag) or drain.
//   result - drained entries in ascending size order, last set on the final one;
//            among equal sizes the earlier insert comes first.
// Timing: the block takes one item at a time; cmd.ready is low while it works.
//   An add walks the store one entry per cycle through a single comparator
//   and one RAM read port; a key rejected at the head compare ends the walk
//   there, and an empty store or a keep of 0 takes the add at once.
//   A drain reads the held entries from the RAM in ascending order; each entry
//   passes through the registered RAM read data and then the result register.
//   A drain of an empty store returns at once and emits nothing.
// Stalls: a full result register with result.ready low holds the drain walk
//   in place; nothing is dropped.
// Reset: rst_n clears the held count, the sequencer and the result valid flag and
//   loads keep_count with 5; the store contents need no clearing.
module top_k_largest_selector (
    input  logic        clk,
    input  logic        rst_n,
    tkls_cfg_if.sink    cfg,
    tkls_cmd_if.sink    cmd,
    tkls_res_if.source  result
);

    logic [tkls_pkg::KEEP_W-1:0] keep_reg;
    logic [tkls_pkg::IDX_W-1:0]  raddr;
    logic [tkls_pkg::ENTRY_W-1:0] rdata;
    tkls_pkg::entry_t            rd_entry;
    tkls_pkg::ram_wr_t           wr;
    tkls_pkg::push_t             push;
    logic                        out_space;

    logic                        res_valid_reg;
    tkls_pkg::entry_t            res_entry_reg;
    logic                        res_last_reg;

    // Configuration is always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= tkls_pkg::KEEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            keep_reg <= cfg.keep_count;
        end
    end

    // Held entries, kept sorted ascending by size.
    tkls_ram #(
        .WIDTH (tkls_pkg::ENTRY_W),
        .DEPTH (tkls_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = rdata;

    tkls_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .keep_count (keep_reg),
        .rd_entry   (rd_entry),
        .out_space  (out_space),
        .raddr      (raddr),
        .wr         (wr),
        .push       (push)
    );

    // Result register: load when empty or being emptied this cycle.
    assign out_space = !res_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            res_valid_reg <= push.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_space && push.valid)
        begin
            res_entry_reg <= push.entry;
            res_last_reg  <= push.last;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.out_size = res_entry_reg.size;
    assign result.out_tag  = res_entry_reg.tag;
    assign result.last     = res_last_reg;

endmodule

>>> tb/sv/top_k_largest_selector_test.sv
// Testbench of the top-K selector: directed and random add/drain traffic with a scoreboard.
`timescale 1ns / 1ps

module top_k_largest_selector_test;

    // Quiet cycles after the last expected item before the keep limit may change.
    // This outlasts the longest add walk, so it covers a full store.
    localparam int SETTLE_CYCLES = 2 * tkls_pkg::CAPACITY + 4;
    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT    = 2000;

    // One drained entry as the result channel should present it.
    typedef struct {
        logic [tkls_pkg::SIZE_W-1:0] size;
        logic [tkls_pkg::TAG_W-1:0]  tag;
        logic                        last;
    } drained_entry_t;

    // Scoreboard: keeps its own sorted copy of the store and the keep limit,
    // turns each accepted drain into the expected item run, and checks results.
    class topk_scoreboard;
        logic [tkls_pkg::KEEP_W-1:0] keep_count;
        tkls_pkg::entry_t            kept[$];          // ascending size, ties in insert order
        drained_entry_t              drain_order_q[$]; // items still owed on the result channel
        int                          errors;
        int                          reported;

        function new();
            keep_count = tkls_pkg::KEEP_RESET;
            errors     = 0;
            reported   = 0;
        endfunction

        function void set_keep(logic [tkls_pkg::KEEP_W-1:0] value);
            keep_count = value;
        endfunction

        function int pending();
            return drain_order_q.size();
        endfunction

        function void take_command(logic op, logic [tkls_pkg::SIZE_W-1:0] sz,
                                   logic [tkls_pkg::TAG_W-1:0] tg);
            int               limit;
            int               pos;
            tkls_pkg::entry_t e;
            drained_entry_t   d;
            if (op == tkls_pkg::OP_ADD)
            begin
                limit  = (keep_count > tkls_pkg::CAPACITY) ? tkls_pkg::CAPACITY
                                                           : int'(keep_count);
                e.size = sz;
                e.tag  = tg;
                if (limit == 0)
                    return;
                if (kept.size() >= limit)
                begin
                    // Full: only a strictly larger key displaces the smallest.
                    if (kept[0].size >= sz)
                        return;
                    void'(kept.pop_front());
                end
                // Insert after every entry with an equal or smaller key.
                pos = 0;
                while (pos < kept.size() && kept[pos].size <= sz)
                    pos++;
                kept.insert(pos, e);
            end
            else
            begin
                foreach (kept[i])
                begin
                    d.size = kept[i].size;
                    d.tag  = kept[i].tag;
                    d.last = (i == kept.size() - 1);
                    drain_order_q.insert(drain_order_q.size(), d);
                end
                kept.delete();
            end
        endfunction

        function void check_drained(logic [tkls_pkg::SIZE_W-1:0] sz,
                                    logic [tkls_pkg::TAG_W-1:0] tg, logic lst);
            drained_entry_t want;
            if (drain_order_q.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected drained item: size %h tag %h last %b", sz, tg, lst);
                end
                return;
            end
            want = drain_order_q.pop_front();
            if (want.size !== sz || want.tag !== tg || want.last !== lst)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("drained item mismatch: expected size %h tag %h last %b,",
                             want.size, want.tag, want.last);
                    $display("                       got size %h tag %h last %b",
                             sz, tg, lst);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tkls_cfg_if cfg_ch ();
    tkls_cmd_if cmd_ch ();
    tkls_res_if res_ch ();

    top_k_largest_selector u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    topk_scoreboard sb = new();

    // Idle pattern: 0 = sender sparse / receiver heavy, 1 = swapped, 2 = no idling.
    int idle_mode;
    int n_adds;
    int n_drains;
    int n_results;
    int n_keep_writes;
    int quiet_cycles;

    always #1 clk = ~clk;

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int sender_pct();
        return (idle_mode == 0) ? 17 : (idle_mode == 1) ? 47 : 0;
    endfunction

    function automatic int receiver_pct();
        return (idle_mode == 0) ? 47 : (idle_mode == 1) ? 17 : 0;
    endfunction

    // Key mix: tiny keys for ties, extremes, single bits, and full-range values.
    function automatic logic [tkls_pkg::SIZE_W-1:0] pick_size();
        logic [63:0] r;
        r = {$urandom, $urandom};
        unique case ($urandom_range(9))
            0, 1, 2, 3: return tkls_pkg::SIZE_W'($urandom_range(7));
            4:          return {tkls_pkg::SIZE_W{1'b1}};
            5:          return '0;
            6:          return tkls_pkg::SIZE_W'(1) << $urandom_range(tkls_pkg::SIZE_W - 1);
            default:    return r[tkls_pkg::SIZE_W-1:0];
        endcase
    endfunction

    function automatic logic [tkls_pkg::TAG_W-1:0] pick_tag();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[tkls_pkg::TAG_W-1:0];
    endfunction

    // Offer one item, idling the sender at random first; note it once accepted.
    task automatic send_item(logic op, logic [tkls_pkg::SIZE_W-1:0] sz,
                             logic [tkls_pkg::TAG_W-1:0] tg);
        while (roll(sender_pct()))
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.entry_size <= sz;
        cmd_ch.entry_tag  <= tg;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.take_command(op, sz, tg);
        if (op == tkls_pkg::OP_ADD)
            n_adds++;
        else
            n_drains++;
    endtask

    task automatic add_entry(logic [tkls_pkg::SIZE_W-1:0] sz, logic [tkls_pkg::TAG_W-1:0] tg);
        send_item(tkls_pkg::OP_ADD, sz, tg);
    endtask

    // Drain payload fields are don't-care; fill them with noise.
    task automatic drain_store();
        send_item(tkls_pkg::OP_DRAIN, pick_size(), pick_tag());
    endtask

    // Drop valid, wait for every owed item, then let a pending add finish.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_keep(logic [tkls_pkg::KEEP_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.keep_count <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_keep(value);
        n_keep_writes++;
    endtask

    // Directed checks at the reset limit of five.
    task automatic run_directed();
        drain_store();                                   // empty store: nothing comes back
        add_entry({tkls_pkg::SIZE_W{1'b1}}, {tkls_pkg::TAG_W{1'b1}});
        add_entry('0, '0);
        add_entry({tkls_pkg::SIZE_W/2{2'b01}}, {tkls_pkg::TAG_W/2{2'b10}});
        add_entry({tkls_pkg::SIZE_W/2{2'b10}}, {tkls_pkg::TAG_W/2{2'b01}});
        add_entry(tkls_pkg::SIZE_W'(100), tkls_pkg::TAG_W'(1));
        add_entry(tkls_pkg::SIZE_W'(100), tkls_pkg::TAG_W'(2));  // full: evicts the zero key
        add_entry('0, tkls_pkg::TAG_W'(3));                      // smaller than all: rejected
        add_entry(tkls_pkg::SIZE_W'(100), tkls_pkg::TAG_W'(4));  // equal to smallest: rejected
        add_entry(tkls_pkg::SIZE_W'(101), tkls_pkg::TAG_W'(5));  // evicts the older 100
        drain_store();
        add_entry(tkls_pkg::SIZE_W'(7), tkls_pkg::TAG_W'(10));   // ties drain in insert order
        add_entry(tkls_pkg::SIZE_W'(7), tkls_pkg::TAG_W'(11));
        add_entry(tkls_pkg::SIZE_W'(7), tkls_pkg::TAG_W'(12));
        drain_store();
        drain_store();
        add_entry(tkls_pkg::SIZE_W'(42), {tkls_pkg::TAG_W{1'b1}}); // a single held entry
        drain_store();
    endtask

    // One random phase at a fixed limit. Close it with adds only, so the store
    // is full when the limit changes and a lowered limit meets a larger store.
    task automatic run_phase(int count);
        for (int j = 0; j < count; j++)
        begin
            if (j < count - 10 && $urandom_range(6) == 0)
                drain_store();
            else
                add_entry(pick_size(), pick_tag());
        end
    endtask

    // Result side: random backpressure, checking, and the hang watchdog.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            quiet_cycles  = 0;
        end
        else
        begin
            res_ch.ready <= !roll(receiver_pct());
            if (res_ch.valid && res_ch.ready)
            begin
                sb.check_drained(res_ch.out_size, res_ch.out_tag, res_ch.last);
                n_results++;
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
                $display("top_k_largest_selector_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        // Limits cover zero, one, full capacity and saturation above it;
        // together they toggle every bit of the register.
        logic [tkls_pkg::KEEP_W-1:0] keep_plan[12];
        keep_plan = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd9, 4'd2, 4'd8, 4'd4, 4'd7, 4'd5};

        clk               = 1'b0;
        rst_n             = 1'b0;
        idle_mode         = 0;
        n_adds            = 0;
        n_drains          = 0;
        n_results         = 0;
        n_keep_writes     = 0;
        quiet_cycles      = 0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = tkls_pkg::OP_ADD;
        cmd_ch.entry_size = '0;
        cmd_ch.entry_tag  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.keep_count = tkls_pkg::KEEP_RESET;
        res_ch.ready      = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases: hold each limit for a run of traffic, then settle and
        // switch. Advance the idle pattern every four phases.
        for (int p = 0; p < 12; p++)
        begin
            idle_mode = p / 4;
            wait_idle();
            write_keep(keep_plan[p]);
            run_phase((keep_plan[p] == 0) ? 12 : 40);
        end

        wait_idle();
        sb.errors += sb.pending();

        $display("covered %0d adds and %0d drains, %0d drained items checked",
                 n_adds, n_drains, n_results);
        $display("limit written %0d times (0, 1, capacity, above capacity), %0d mismatches",
                 n_keep_writes, sb.errors);
        if (sb.errors == 0)
            $display("top_k_largest_selector_test OK");
        else
            $display("top_k_largest_selector_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tkls_pkg.sv
rtl/core/tkls_if.sv
rtl/core/tkls_ram.sv
rtl/core/tkls_engine.sv
rtl/core/top_k_largest_selector.sv
tb/sv/top_k_largest_selector_test.sv
